// ----- hdl/ece_pkg.sv -----
// ----------------------------------------------------------------------------
// ece_pkg
// Types, constants and arithmetic helpers for the easing curve evaluator.
// ----------------------------------------------------------------------------
package ece_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // internal Q format
    localparam int QB = 28;
    localparam int QW = 32;
    typedef logic signed [QW-1:0] t_q;

    localparam t_q Q_ONE  = t_q'(64'sd1 <<< QB);
    localparam t_q Q_HALF = t_q'(64'sd1 <<< (QB - 1));
    localparam t_q Q_TWO  = t_q'(64'sd1 <<< (QB + 1));

    localparam t_q PI_HALF_Q = t_q'(421657428);
    localparam t_q LN2_Q     = t_q'(186065280);
    localparam t_q BACK_C1   = t_q'(456764403);
    localparam t_q BACK_C2   = t_q'(696565715);
    localparam t_q BACK_C1P1 = t_q'(456764403 + (1 << QB));
    localparam t_q BACK_C2P1 = t_q'(696565715 + (1 << QB));

    // sine series coefficients, innermost first
    localparam t_q SIN_K0 = t_q'(7);
    localparam t_q SIN_K1 = t_q'(740);
    localparam t_q SIN_K2 = t_q'(53261);
    localparam t_q SIN_K3 = t_q'(2236962);
    localparam t_q SIN_K4 = t_q'(44739243);

    // curve codes
    localparam logic [4:0] F_IN_SINE    = 5'd0;
    localparam logic [4:0] F_OUT_SINE   = 5'd1;
    localparam logic [4:0] F_INOUT_SINE = 5'd2;
    localparam logic [4:0] F_IN_CUBIC   = 5'd3;
    localparam logic [4:0] F_OUT_CUBIC  = 5'd4;
    localparam logic [4:0] F_INOUT_CUBIC= 5'd5;
    localparam logic [4:0] F_IN_QUINT   = 5'd6;
    localparam logic [4:0] F_OUT_QUINT  = 5'd7;
    localparam logic [4:0] F_INOUT_QUINT= 5'd8;
    localparam logic [4:0] F_IN_CIRC    = 5'd9;
    localparam logic [4:0] F_OUT_CIRC   = 5'd10;
    localparam logic [4:0] F_INOUT_CIRC = 5'd11;
    localparam logic [4:0] F_IN_QUAD    = 5'd12;
    localparam logic [4:0] F_OUT_QUAD   = 5'd13;
    localparam logic [4:0] F_INOUT_QUAD = 5'd14;
    localparam logic [4:0] F_IN_QUART   = 5'd15;
    localparam logic [4:0] F_OUT_QUART  = 5'd16;
    localparam logic [4:0] F_INOUT_QUART= 5'd17;
    localparam logic [4:0] F_IN_EXPO    = 5'd18;
    localparam logic [4:0] F_OUT_EXPO   = 5'd19;
    localparam logic [4:0] F_INOUT_EXPO = 5'd20;
    localparam logic [4:0] F_IN_BACK    = 5'd21;
    localparam logic [4:0] F_OUT_BACK   = 5'd22;
    localparam logic [4:0] F_INOUT_BACK = 5'd23;

    // stage map
    localparam int ST_M1       = 1;
    localparam int ST_M2       = 2;
    localparam int ST_M3       = 3;
    localparam int ST_M4       = 4;
    localparam int ST_P2       = 5;
    localparam int ST_P3       = 6;
    localparam int ST_P4       = 7;
    localparam int ST_SIN      = 8;
    localparam int ST_SIN_SQ   = 9;
    localparam int SQ_ITERS    = 29;
    localparam int SQ_PER_ST   = 3;
    localparam int SQ_ST       = (SQ_ITERS + SQ_PER_ST - 1) / SQ_PER_ST;
    localparam int ST_SQ_FIRST = 2;
    localparam int SQW         = 2 * QB + 2;
    localparam int EXP_TERMS   = 11;
    localparam int ST_EXP_FIRST= 2;
    localparam int ST_EXP_SH   = ST_EXP_FIRST + 2 * EXP_TERMS;
    localparam int ST_COMB     = ST_EXP_SH + 1;
    localparam int N_ST        = ST_COMB + 1;
    localparam int DIV_SH      = 33;
    localparam int DIV_QW      = 29;

    typedef struct packed {
        logic [4:0]     func;
        logic           half;
        logic           xz;
        logic           xo;
        t_q             ts;
        t_q             u;
        t_q             u2;
        t_q             p;
        t_q             s;
        t_q             ss;
        t_q             a;
        t_q             a2;
        t_q             a3;
        t_q             a4;
        t_q             a5;
        logic [SQW-1:0] sn;
        logic [SQW-1:0] sr;
        t_q             b;
        t_q             b2;
        t_q             b3;
        t_q             w;
        t_q             cc;
        t_q             z;
        t_q             d;
        logic [3:0]     ek;
        logic           ef0;
        t_q             g;
        t_q             y;
        t_q             er;
        t_q             eq;
        t_q             e;
        t_q             res;
    } t_stg;

    // Q28 product, rounded to nearest, ties away from zero
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [63:0] p;
        logic [63:0]        mag;
        logic [63:0]        rnd;
        t_q                 rq;
        p   = 64'(a) * 64'(b);
        mag = p[63] ? 64'(-p) : 64'(p);
        rnd = (mag + (64'd1 << (QB - 1))) >> QB;
        rq  = t_q'(rnd[QW-1:0]);
        qmul = p[63] ? -rq : rq;
    endfunction

    // halve, truncating toward zero
    function automatic t_q half_tz(input t_q v);
        half_tz = (v + t_q'(v[QW-1])) >>> 1;
    endfunction

endpackage

// ----- hdl/easing_curve_evaluator.sv -----
// ----------------------------------------------------------------------------
// easing_curve_evaluator
// Fixed-point Penner easing curves (Sine, Cubic, Quint, Circ, Quad, Quart,
// Expo, Back; In, Out and InOut) on a fully pipelined datapath.
// ----------------------------------------------------------------------------
// One transfer in per cycle, one result out per cycle. The pipeline length is
// set by the exp2 series (eleven multiply and constant-divide steps, two
// stages each). A stall while the output holds a result freezes the whole
// pipeline. Codes 24 to 31 give zero; positions above 1.0 are clamped.
module easing_curve_evaluator #(
    parameter int FRAC_BITS = ece_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [4:0]             i_func,
    input  logic [FRAC_BITS:0]     i_position,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [FRAC_BITS+1:0] o_eased_value
);

    localparam int IW  = FRAC_BITS + 1;
    localparam int OW  = FRAC_BITS + 2;
    localparam int RSH = ece_pkg::QB - FRAC_BITS;
    localparam int NS  = ece_pkg::N_ST;
    localparam logic [IW-1:0] POS_ONE = IW'(1) << FRAC_BITS;
    localparam logic signed [34:0] OMAX = 35'((64'sd1 <<< (OW - 1)) - 64'sd1);
    localparam logic signed [34:0] OMIN = 35'(-(64'sd1 <<< (OW - 1)));
    localparam logic [33:0] TEN_ONE = 34'd10 << ece_pkg::QB;

    ece_pkg::t_stg r_st [NS];
    ece_pkg::t_stg n_st [NS];
    logic [NS-1:0] r_vld;
    logic          r_ovld;
    logic signed [OW-1:0] r_out;
    logic signed [OW-1:0] n_out;
    logic          en;

    assign en            = !(r_ovld && i_stall);
    assign o_stall       = !en;
    assign o_valid       = r_ovld;
    assign o_eased_value = r_out;

    // input stage: clamp, curve bases, exponent argument
    always_comb begin
        logic [IW-1:0]   pos_c;
        ece_pkg::t_q     x;
        logic [33:0]     xs;
        logic [33:0]     mexp;
        n_st[0] = '0;
        pos_c = (i_position > POS_ONE) ? POS_ONE : i_position;
        x     = ece_pkg::t_q'({pos_c, {RSH{1'b0}}});
        xs    = 34'($unsigned(x));
        n_st[0].func = i_func;
        n_st[0].half = x < ece_pkg::Q_HALF;
        n_st[0].xz   = x == '0;
        n_st[0].xo   = x == ece_pkg::Q_ONE;
        n_st[0].ts   = (i_func == ece_pkg::F_IN_SINE) ? ece_pkg::Q_ONE - x : x;

        case (i_func)
            ece_pkg::F_OUT_CUBIC, ece_pkg::F_OUT_QUINT, ece_pkg::F_OUT_CIRC,
            ece_pkg::F_OUT_QUAD, ece_pkg::F_OUT_QUART: begin
                n_st[0].a = ece_pkg::Q_ONE - x;
            end
            ece_pkg::F_INOUT_CUBIC, ece_pkg::F_INOUT_QUINT, ece_pkg::F_INOUT_CIRC,
            ece_pkg::F_INOUT_QUAD, ece_pkg::F_INOUT_QUART: begin
                n_st[0].a = n_st[0].half ? x <<< 1 : (ece_pkg::Q_ONE - x) <<< 1;
            end
            default: begin
                n_st[0].a = x;
            end
        endcase

        case (i_func)
            ece_pkg::F_OUT_BACK: begin
                n_st[0].b = x - ece_pkg::Q_ONE;
            end
            ece_pkg::F_INOUT_BACK: begin
                n_st[0].b = n_st[0].half ? x <<< 1 : (x - ece_pkg::Q_ONE) <<< 1;
            end
            default: begin
                n_st[0].b = x;
            end
        endcase

        case (i_func)
            ece_pkg::F_IN_EXPO: begin
                mexp = 34'd10 * (34'($unsigned(ece_pkg::Q_ONE)) - xs);
            end
            ece_pkg::F_OUT_EXPO: begin
                mexp = 34'd10 * xs;
            end
            ece_pkg::F_INOUT_EXPO: begin
                mexp = n_st[0].half ? TEN_ONE - 34'd20 * xs : 34'd20 * xs - TEN_ONE;
            end
            default: begin
                mexp = '0;
            end
        endcase
        n_st[0].ek  = mexp[31:28];
        n_st[0].ef0 = mexp[27:0] == '0;
        n_st[0].g   = ece_pkg::Q_ONE - ece_pkg::t_q'({4'b0, mexp[27:0]});
    end

    for (genvar gi = 1; gi < NS; gi++) begin : g_stage
        localparam int EXP_STEP = (gi - ece_pkg::ST_EXP_FIRST) / 2;
        localparam int DN = (EXP_STEP < ece_pkg::EXP_TERMS) ?
                            ece_pkg::EXP_TERMS - EXP_STEP : 1;
        localparam logic [32:0] RCP =
            33'(((64'd1 << ece_pkg::DIV_SH) + 64'(DN) - 64'd1) / 64'(DN));
        localparam int SQ_BASE = (gi - ece_pkg::ST_SQ_FIRST) * ece_pkg::SQ_PER_ST;

        always_comb begin
            logic [ece_pkg::SQW-1:0] sn;
            logic [ece_pkg::SQW-1:0] sr;
            logic [ece_pkg::SQW-1:0] sb;
            logic [61:0]             dprod;
            ece_pkg::t_q             v;
            logic [4:0]              sh;
            logic [32:0]             ev;
            ece_pkg::t_q             pw;
            ece_pkg::t_q             rt;
            n_st[gi] = r_st[gi-1];
            sn = '0;
            sr = '0;
            sb = '0;
            dprod = '0;
            v = '0;
            sh = '0;
            ev = '0;
            pw = '0;
            rt = '0;

            if (gi == ece_pkg::ST_M1) begin
                n_st[gi].u  = ece_pkg::qmul(r_st[gi-1].ts, ece_pkg::PI_HALF_Q);
                n_st[gi].a2 = ece_pkg::qmul(r_st[gi-1].a, r_st[gi-1].a);
                n_st[gi].b2 = ece_pkg::qmul(r_st[gi-1].b, r_st[gi-1].b);
                n_st[gi].w  = ece_pkg::qmul(ece_pkg::BACK_C2P1, r_st[gi-1].b);
                n_st[gi].y  = ece_pkg::qmul(r_st[gi-1].g, ece_pkg::LN2_Q);
                n_st[gi].er = ece_pkg::Q_ONE;
            end
            if (gi == ece_pkg::ST_M2) begin
                n_st[gi].u2 = ece_pkg::qmul(r_st[gi-1].u, r_st[gi-1].u);
                n_st[gi].a3 = ece_pkg::qmul(r_st[gi-1].a2, r_st[gi-1].a);
                n_st[gi].b3 = ece_pkg::qmul(r_st[gi-1].b2, r_st[gi-1].b);
                n_st[gi].cc = ece_pkg::qmul(ece_pkg::BACK_C1, r_st[gi-1].b2);
                n_st[gi].z  = ece_pkg::qmul(r_st[gi-1].b2, r_st[gi-1].half ?
                              r_st[gi-1].w - ece_pkg::BACK_C2 :
                              r_st[gi-1].w + ece_pkg::BACK_C2);
            end
            if (gi == ece_pkg::ST_M3) begin
                n_st[gi].p  = ece_pkg::SIN_K1 -
                              ece_pkg::qmul(r_st[gi-1].u2, ece_pkg::SIN_K0);
                n_st[gi].a4 = ece_pkg::qmul(r_st[gi-1].a3, r_st[gi-1].a);
                n_st[gi].d  = ece_pkg::qmul(ece_pkg::BACK_C1P1, r_st[gi-1].b3);
            end
            if (gi == ece_pkg::ST_M4) begin
                n_st[gi].p  = ece_pkg::SIN_K2 -
                              ece_pkg::qmul(r_st[gi-1].u2, r_st[gi-1].p);
                n_st[gi].a5 = ece_pkg::qmul(r_st[gi-1].a4, r_st[gi-1].a);
            end
            if (gi == ece_pkg::ST_P2) begin
                n_st[gi].p = ece_pkg::SIN_K3 - ece_pkg::qmul(r_st[gi-1].u2, r_st[gi-1].p);
            end
            if (gi == ece_pkg::ST_P3) begin
                n_st[gi].p = ece_pkg::SIN_K4 - ece_pkg::qmul(r_st[gi-1].u2, r_st[gi-1].p);
            end
            if (gi == ece_pkg::ST_P4) begin
                n_st[gi].p = ece_pkg::Q_ONE - ece_pkg::qmul(r_st[gi-1].u2, r_st[gi-1].p);
            end
            if (gi == ece_pkg::ST_SIN) begin
                v = ece_pkg::qmul(r_st[gi-1].u, r_st[gi-1].p);
                if (v < 0) begin
                    v = '0;
                end
                if (v > ece_pkg::Q_ONE) begin
                    v = ece_pkg::Q_ONE;
                end
                n_st[gi].s = v;
            end
            if (gi == ece_pkg::ST_SIN_SQ) begin
                n_st[gi].ss = ece_pkg::qmul(r_st[gi-1].s, r_st[gi-1].s);
            end

            // bitwise square root, a few steps per stage
            if (gi >= ece_pkg::ST_SQ_FIRST &&
                gi < ece_pkg::ST_SQ_FIRST + ece_pkg::SQ_ST) begin
                if (gi == ece_pkg::ST_SQ_FIRST) begin
                    sn = ece_pkg::SQW'($unsigned(ece_pkg::Q_ONE - r_st[gi-1].a2))
                         << ece_pkg::QB;
                    sr = '0;
                end else begin
                    sn = r_st[gi-1].sn;
                    sr = r_st[gi-1].sr;
                end
                for (int j = 0; j < ece_pkg::SQ_PER_ST; j++) begin
                    if (SQ_BASE + j < ece_pkg::SQ_ITERS) begin
                        sb = ece_pkg::SQW'(1) << (2 * ece_pkg::QB - 2 * (SQ_BASE + j));
                        if (sn >= sr + sb) begin
                            sn = sn - (sr + sb);
                            sr = (sr >> 1) + sb;
                        end else begin
                            sr = sr >> 1;
                        end
                    end
                end
                n_st[gi].sn = sn;
                n_st[gi].sr = sr;
            end

            // exp series: multiply, then divide by the term index
            if (gi >= ece_pkg::ST_EXP_FIRST && gi < ece_pkg::ST_EXP_SH) begin
                if (((gi - ece_pkg::ST_EXP_FIRST) % 2) == 0) begin
                    n_st[gi].eq = ece_pkg::qmul(r_st[gi-1].y, r_st[gi-1].er);
                end else if (DN == 1) begin
                    n_st[gi].er = ece_pkg::Q_ONE + r_st[gi-1].eq;
                end else begin
                    dprod = 62'(r_st[gi-1].eq[ece_pkg::DIV_QW-1:0]) * 62'(RCP);
                    n_st[gi].er = ece_pkg::Q_ONE +
                                  ece_pkg::t_q'(dprod[61:ece_pkg::DIV_SH]);
                end
            end
            if (gi == ece_pkg::ST_EXP_SH) begin
                v  = r_st[gi-1].ef0 ? ece_pkg::Q_ONE : r_st[gi-1].er;
                sh = r_st[gi-1].ef0 ? {1'b0, r_st[gi-1].ek} : {1'b0, r_st[gi-1].ek} + 5'd1;
                ev = (33'($unsigned(v)) + ((33'd1 << sh) >> 1)) >> sh;
                n_st[gi].e = ece_pkg::t_q'(ev);
            end

            if (gi == ece_pkg::ST_COMB) begin
                rt = ece_pkg::t_q'(r_st[gi-1].sr[ece_pkg::QW-1:0]);
                case (r_st[gi-1].func)
                    ece_pkg::F_IN_CUBIC, ece_pkg::F_OUT_CUBIC, ece_pkg::F_INOUT_CUBIC: begin
                        pw = r_st[gi-1].a3;
                    end
                    ece_pkg::F_IN_QUINT, ece_pkg::F_OUT_QUINT, ece_pkg::F_INOUT_QUINT: begin
                        pw = r_st[gi-1].a5;
                    end
                    ece_pkg::F_IN_QUART, ece_pkg::F_OUT_QUART, ece_pkg::F_INOUT_QUART: begin
                        pw = r_st[gi-1].a4;
                    end
                    default: begin
                        pw = r_st[gi-1].a2;
                    end
                endcase
                case (r_st[gi-1].func)
                    ece_pkg::F_IN_SINE: begin
                        v = ece_pkg::Q_ONE - r_st[gi-1].s;
                    end
                    ece_pkg::F_OUT_SINE: begin
                        v = r_st[gi-1].s;
                    end
                    ece_pkg::F_INOUT_SINE: begin
                        v = r_st[gi-1].ss;
                    end
                    ece_pkg::F_IN_CUBIC, ece_pkg::F_IN_QUINT, ece_pkg::F_IN_QUAD,
                    ece_pkg::F_IN_QUART: begin
                        v = pw;
                    end
                    ece_pkg::F_OUT_CUBIC, ece_pkg::F_OUT_QUINT, ece_pkg::F_OUT_QUAD,
                    ece_pkg::F_OUT_QUART: begin
                        v = ece_pkg::Q_ONE - pw;
                    end
                    ece_pkg::F_INOUT_CUBIC, ece_pkg::F_INOUT_QUINT, ece_pkg::F_INOUT_QUAD,
                    ece_pkg::F_INOUT_QUART: begin
                        v = r_st[gi-1].half ? pw >>> 1 : ece_pkg::Q_ONE - (pw >>> 1);
                    end
                    ece_pkg::F_IN_CIRC: begin
                        v = ece_pkg::Q_ONE - rt;
                    end
                    ece_pkg::F_OUT_CIRC: begin
                        v = rt;
                    end
                    ece_pkg::F_INOUT_CIRC: begin
                        v = r_st[gi-1].half ? (ece_pkg::Q_ONE - rt) >>> 1 :
                                              (rt + ece_pkg::Q_ONE) >>> 1;
                    end
                    ece_pkg::F_IN_EXPO: begin
                        v = r_st[gi-1].xz ? '0 : r_st[gi-1].e;
                    end
                    ece_pkg::F_OUT_EXPO: begin
                        v = r_st[gi-1].xo ? ece_pkg::Q_ONE : ece_pkg::Q_ONE - r_st[gi-1].e;
                    end
                    ece_pkg::F_INOUT_EXPO: begin
                        if (r_st[gi-1].xz) begin
                            v = '0;
                        end else if (r_st[gi-1].xo) begin
                            v = ece_pkg::Q_ONE;
                        end else if (r_st[gi-1].half) begin
                            v = r_st[gi-1].e >>> 1;
                        end else begin
                            v = (ece_pkg::Q_TWO - r_st[gi-1].e) >>> 1;
                        end
                    end
                    ece_pkg::F_IN_BACK: begin
                        v = r_st[gi-1].d - r_st[gi-1].cc;
                    end
                    ece_pkg::F_OUT_BACK: begin
                        v = ece_pkg::Q_ONE + r_st[gi-1].d + r_st[gi-1].cc;
                    end
                    ece_pkg::F_INOUT_BACK: begin
                        v = r_st[gi-1].half ? ece_pkg::half_tz(r_st[gi-1].z) :
                            ece_pkg::half_tz(r_st[gi-1].z + ece_pkg::Q_TWO);
                    end
                    default: begin
                        v = '0;
                    end
                endcase
                n_st[gi].res = v;
            end
        end
    end

    // round to output precision and saturate
    always_comb begin
        ece_pkg::t_q        res;
        logic [32:0]        mag;
        logic [33:0]        rm;
        logic signed [34:0] sv;
        res = r_st[NS-1].res;
        mag = res[ece_pkg::QW-1] ? 33'($unsigned(-res)) : 33'($unsigned(res));
        rm  = 34'((mag + (33'd1 << (RSH - 1))) >> RSH);
        sv  = res[ece_pkg::QW-1] ? -35'(rm) : 35'(rm);
        if (sv > OMAX) begin
            sv = OMAX;
        end else if (sv < OMIN) begin
            sv = OMIN;
        end
        n_out = OW'(sv);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NS; k++) begin
                r_st[k] <= n_st[k];
            end
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[NS-2:0], i_valid};
            r_ovld <= r_vld[NS-1];
        end
    end

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0) && !r_ovld)
        else $error("pipeline valid bits not cleared by reset");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_vld == $past(r_vld)) && $stable(r_out))
        else $error("pipeline moved during output stall");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[NS-1] |=> o_valid)
        else $error("result lost between last stage and output");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] && (r_st[NS-1].func < ece_pkg::F_IN_EXPO ||
                        r_st[NS-1].func > ece_pkg::F_INOUT_BACK)
        |-> r_st[NS-1].res >= 0 && r_st[NS-1].res <= ece_pkg::Q_ONE)
        else $error("bounded curve left the unit interval");

endmodule

// ----- verif/easing_curve_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// easing_curve_checker
// Watches both channels of the easing curve evaluator, predicts each eased
// value from the accepted curve code and position, and compares in order.
// ----------------------------------------------------------------------------
module easing_curve_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [4:0]         i_func,
    input  logic [16:0]        i_position,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [17:0] i_eased_value,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);

    localparam longint ONE  = 64'sd1 << 28;
    localparam longint HALF = 64'sd1 << 27;

    logic signed [17:0] eased_q[$];

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        if (p < 0) begin
            m = (-p + HALF) >>> 28;
            return -m;
        end
        return (p + HALF) >>> 28;
    endfunction

    function automatic longint fx_pow(longint a, int n);
        longint r;
        r = ONE;
        for (int i = 0; i < n; i++) r = fx_mul(r, a);
        return r;
    endfunction

    function automatic longint quarter_sine(longint t);
        longint u;
        longint u2;
        longint p;
        u  = fx_mul(t, 421657428);
        u2 = fx_mul(u, u);
        p  = 7;
        p  = 740 - fx_mul(u2, p);
        p  = 53261 - fx_mul(u2, p);
        p  = 2236962 - fx_mul(u2, p);
        p  = 44739243 - fx_mul(u2, p);
        p  = ONE - fx_mul(u2, p);
        p  = fx_mul(u, p);
        if (p < 0) p = 0;
        if (p > ONE) p = ONE;
        return p;
    endfunction

    function automatic longint root_trunc(longint v);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        if (v <= 0) return 0;
        n = 64'(v) << 28;
        r = 0;
        b = 64'd1 << 56;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint pow2_neg(longint m);
        longint k;
        longint f;
        longint v;
        longint y;
        int     s;
        k = m >>> 28;
        f = m & (ONE - 1);
        if (f == 0) begin
            v = ONE;
            s = int'(k);
        end else begin
            y = fx_mul(ONE - f, 186065280);
            v = ONE;
            for (int n = 11; n >= 1; n--) v = ONE + fx_mul(y, v) / n;
            s = int'(k) + 1;
        end
        if (s == 0) return v;
        if (s > 40) return 0;
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint power_curve(int kind, int n, longint x);
        if (kind == 0) return fx_pow(x, n);
        if (kind == 1) return ONE - fx_pow(ONE - x, n);
        if (x < HALF) return fx_pow(2 * x, n) / 2;
        return ONE - fx_pow(2 * ONE - 2 * x, n) / 2;
    endfunction

    function automatic longint curve_value(logic [4:0] f, longint x);
        longint t;
        longint c1;
        longint c2;
        c1 = 456764403;
        c2 = 696565715;
        case (f)
            ece_pkg::F_IN_SINE:     return ONE - quarter_sine(ONE - x);
            ece_pkg::F_OUT_SINE:    return quarter_sine(x);
            ece_pkg::F_INOUT_SINE: begin
                t = quarter_sine(x);
                return fx_mul(t, t);
            end
            ece_pkg::F_IN_CUBIC, ece_pkg::F_OUT_CUBIC, ece_pkg::F_INOUT_CUBIC:
                return power_curve(int'(f - ece_pkg::F_IN_CUBIC), 3, x);
            ece_pkg::F_IN_QUINT, ece_pkg::F_OUT_QUINT, ece_pkg::F_INOUT_QUINT:
                return power_curve(int'(f - ece_pkg::F_IN_QUINT), 5, x);
            ece_pkg::F_IN_CIRC:     return ONE - root_trunc(ONE - fx_mul(x, x));
            ece_pkg::F_OUT_CIRC: begin
                t = x - ONE;
                return root_trunc(ONE - fx_mul(t, t));
            end
            ece_pkg::F_INOUT_CIRC: begin
                if (x < HALF) begin
                    t = 2 * x;
                    return (ONE - root_trunc(ONE - fx_mul(t, t))) / 2;
                end
                t = 2 * ONE - 2 * x;
                return (root_trunc(ONE - fx_mul(t, t)) + ONE) / 2;
            end
            ece_pkg::F_IN_QUAD, ece_pkg::F_OUT_QUAD, ece_pkg::F_INOUT_QUAD:
                return power_curve(int'(f - ece_pkg::F_IN_QUAD), 2, x);
            ece_pkg::F_IN_QUART, ece_pkg::F_OUT_QUART, ece_pkg::F_INOUT_QUART:
                return power_curve(int'(f - ece_pkg::F_IN_QUART), 4, x);
            ece_pkg::F_IN_EXPO: begin
                if (x == 0) return 0;
                return pow2_neg(10 * (ONE - x));
            end
            ece_pkg::F_OUT_EXPO: begin
                if (x == ONE) return ONE;
                return ONE - pow2_neg(10 * x);
            end
            ece_pkg::F_INOUT_EXPO: begin
                if (x == 0) return 0;
                if (x == ONE) return ONE;
                if (x < HALF) return pow2_neg(10 * ONE - 20 * x) / 2;
                return (2 * ONE - pow2_neg(20 * x - 10 * ONE)) / 2;
            end
            ece_pkg::F_IN_BACK: begin
                t = fx_mul(x, x);
                return fx_mul(c1 + ONE, fx_mul(t, x)) - fx_mul(c1, t);
            end
            ece_pkg::F_OUT_BACK: begin
                t = x - ONE;
                return ONE + fx_mul(c1 + ONE, fx_pow(t, 3)) + fx_mul(c1, fx_mul(t, t));
            end
            ece_pkg::F_INOUT_BACK: begin
                if (x < HALF) begin
                    t = 2 * x;
                    return fx_mul(fx_mul(t, t), fx_mul(c2 + ONE, t) - c2) / 2;
                end
                t = 2 * x - 2 * ONE;
                return (fx_mul(fx_mul(t, t), fx_mul(c2 + ONE, t) + c2) + 2 * ONE) / 2;
            end
            default:       return 0;
        endcase
    endfunction

    function automatic logic signed [17:0] predict_eased(logic [4:0] f, logic [16:0] pos);
        longint x;
        longint r;
        longint v;
        x = (pos > 17'd65536) ? 65536 : longint'(pos);
        r = curve_value(f, x << 12);
        if (r < 0) v = -((-r + 2048) >>> 12);
        else v = (r + 2048) >>> 12;
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return 18'(v);
    endfunction

    assign o_pending = eased_q.size();

    always_ff @(posedge i_clk) begin
        logic signed [17:0] exp_v;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_results <= 0;
            eased_q.delete();
        end else begin
            if (i_valid && !i_stall_in) eased_q.push_back(predict_eased(i_func, i_position));
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (eased_q.size() == 0) begin
                    $display("%0t: unexpected transfer, actual %0d", $time, i_eased_value);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_v = eased_q.pop_front();
                    if (exp_v !== i_eased_value) begin
                        $display("%0t: eased_value mismatch, expected %0d actual %0d",
                                 $time, exp_v, i_eased_value);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- verif/easing_curve_evaluator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// easing_curve_evaluator_tb
// Drives curve codes and positions into the evaluator, covering every curve,
// the unused codes, endpoints, the midpoint and out-of-range positions, with
// random bursts and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module easing_curve_evaluator_tb;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [4:0]         i_func;
    logic [16:0]        i_position;
    logic               o_valid;
    logic               i_stall;
    logic signed [17:0] o_eased_value;
    int                 errors;
    int                 pending;
    int                 results;
    int                 sent;
    bit                 hold_rx;

    easing_curve_evaluator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_eased_value(o_eased_value)
    );

    easing_curve_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_stall_in   (o_stall),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_eased_value(o_eased_value),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // one transfer; valid stays high when the next one follows directly
    task automatic send_item(input logic [4:0] f, input logic [16:0] pos, input bit keep);
        i_func     <= f;
        i_position <= pos;
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if (!keep) i_valid <= 1'b0;
    endtask

    function automatic logic [16:0] rand_pos();
        case ($urandom_range(0, 9))
            0:       return 17'($urandom_range(65537, 131071));
            1:       return 17'd65536;
            2:       return 17'($urandom_range(32760, 32776));
            3:       return 17'($urandom_range(0, 8));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // receiver: random stalls, quiet stretches, and one long hold-off
    initial begin
        int mode;
        i_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (80) @(negedge i_clk);
                hold_rx = 1'b0;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 20)) begin
                i_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
                @(negedge i_clk);
            end
        end
    end

    initial begin
        logic [16:0] edge_pos[6];
        int burst;
        int gap;
        edge_pos = '{17'd0, 17'd1, 17'd32767, 17'd32768, 17'd65536, 17'h1FFFF};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = '0;
        i_position = '0;
        sent = 0;
        hold_rx = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int f = 0; f < 32; f++) begin
            send_item(5'(f), edge_pos[f % 6], 1'b1);
            sent++;
        end
        foreach (edge_pos[k]) begin
            send_item(ece_pkg::F_INOUT_EXPO, edge_pos[k], 1'b1);
            sent++;
        end

        // long receiver hold-off while items keep coming
        hold_rx = 1'b1;
        repeat (60) begin
            send_item(5'($urandom_range(0, 23)), rand_pos(), 1'b1);
            sent++;
        end
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        while (sent < 540) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                send_item(($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                          : 5'($urandom_range(0, 23)), rand_pos(), 1'b1);
                sent++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("Sent %0d items over all 32 codes; %0d results checked.", sent, results);
        if (errors == 0) begin
            $display("easing_curve_evaluator_tb: clean");
        end else begin
            $display("easing_curve_evaluator_tb: errors");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("easing_curve_evaluator_tb: errors");
        $finish;
    end

endmodule
